### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_CLK_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NORST(label, clk, prop)
`endif

`endif

### rtl/core/lfo_pkg.sv
// ----------------------------------------------------------------------------
// LFO package
// Shared types, constants and waveform functions of the LFO block.
// ----------------------------------------------------------------------------
package lfo_pkg;

  localparam logic [31:0] MixAdd  = 32'h9E37_79B9;
  localparam logic [31:0] MixMul1 = 32'h85EB_CA6B;
  localparam logic [31:0] MixMul2 = 32'hC2B2_AE35;
  localparam logic [31:0] InitSeed = 32'd1;

  typedef enum logic [2:0] {
    SHAPE_SQUARE   = 3'd0,
    SHAPE_TRIANGLE = 3'd1,
    SHAPE_SAW_UP   = 3'd2,
    SHAPE_SAW_DOWN = 3'd3,
    SHAPE_HOLD     = 3'd4
  } shape_t;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_RESEED = 1'b1
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic mix_init;   // start mix with the power-up seed
    logic mix_seed;   // start mix with the seed input
    logic mul1;
    logic mul2;
    logic finish;     // finalize, load generator, clear phase
    logic tick;
  } lfo_cmd_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  function automatic logic [16:0] shape_level(input logic [2:0] shape,
                                              input logic [31:0] p,
                                              input logic [15:0] hold);
    logic [32:0] rest;
    logic [16:0] lvl;
    rest = 33'h1_0000_0000 - {1'b0, p};
    unique case (shape)
      SHAPE_SQUARE:   lvl = p[31] ? 17'h1_0000 : 17'd0;
      SHAPE_TRIANGLE: lvl = p[31] ? rest[31:15] : p[31:15];
      SHAPE_SAW_UP:   lvl = {1'b0, p[31:16]};
      SHAPE_SAW_DOWN: lvl = rest[32:16];
      SHAPE_HOLD:     lvl = {1'b0, hold};
      default:        lvl = 17'd0;
    endcase
    return lvl;
  endfunction

endpackage

### rtl/core/lfo_ctrl.sv
// ----------------------------------------------------------------------------
// LFO controller
// Sequences reseed mixing and ticks; owns the input and output handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfo_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             op,
  output logic             out_valid,
  input  logic             out_stall,
  output lfo_pkg::lfo_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_INIT = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_MUL1 = 5'b00100,
    ST_MUL2 = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   accept;

  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      ST_INIT: begin
        cmd.mix_init = 1'b1;
        state_next   = ST_MUL1;
      end
      ST_IDLE: begin
        if (accept) begin
          if (op == lfo_pkg::OP_RESEED) begin
            cmd.mix_seed = 1'b1;
            state_next   = ST_MUL1;
          end else begin
            cmd.tick       = 1'b1;
            out_valid_next = 1'b1;
          end
        end
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `ASSERT_CLK(a_tick_gives_word, clk, rst,
    (accept && op == lfo_pkg::OP_TICK) |=> out_valid)
  `ASSERT_CLK(a_reseed_len, clk, rst,
    (accept && op == lfo_pkg::OP_RESEED) |-> ##4 (state == ST_IDLE))
  `ASSERT_CLK_NORST(a_reset_init, clk, rst |=> (state == ST_INIT && !out_valid))

endmodule

### rtl/core/lfo_dp.sv
// ----------------------------------------------------------------------------
// LFO datapath
// Phase accumulator, xorshift generator, seed mixer and level register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfo_dp (
  input  logic              clk,
  input  logic              rst,
  input  lfo_pkg::lfo_cmd_t cmd,
  input  logic              cfg_valid,
  input  logic [2:0]        wave_shape,
  input  logic [31:0]       phase_step,
  input  logic [31:0]       seed,
  output logic [16:0]       level
);

  logic [2:0]  shape;
  logic [31:0] phase_acc;
  logic [31:0] rng_word;
  logic [15:0] hold_level;
  logic [31:0] mix;

  logic [31:0] mix_src;
  logic [31:0] mix_sum;
  logic [31:0] mix_x13;
  logic [31:0] fin_z;
  logic [31:0] fin_nz;
  logic [31:0] rng_fin;
  logic [31:0] rng_tick;
  logic [32:0] phase_sum;

  assign mix_src   = cmd.mix_init ? lfo_pkg::InitSeed : seed;
  assign mix_sum   = mix_src + lfo_pkg::MixAdd;
  assign mix_x13   = mix ^ (mix >> 13);
  assign fin_z     = mix ^ (mix >> 16);
  assign fin_nz    = (fin_z == 32'd0) ? 32'd1 : fin_z;
  assign rng_fin   = lfo_pkg::xorshift32(fin_nz);
  assign rng_tick  = lfo_pkg::xorshift32(rng_word);
  assign phase_sum = {1'b0, phase_acc} + {1'b0, phase_step};

  always_ff @(posedge clk) begin
    if (rst) begin
      shape <= lfo_pkg::SHAPE_SQUARE;
    end else if (cfg_valid) begin
      shape <= wave_shape;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (cmd.finish) begin
      phase_acc <= '0;
    end else if (cmd.tick) begin
      phase_acc <= phase_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mix_init || cmd.mix_seed) begin
      mix <= mix_sum ^ (mix_sum >> 16);
    end else if (cmd.mul1) begin
      mix <= mix * lfo_pkg::MixMul1;
    end else if (cmd.mul2) begin
      mix <= mix_x13 * lfo_pkg::MixMul2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rng_word   <= rng_fin;
      hold_level <= rng_fin[31:16];
    end else if (cmd.tick && phase_sum[32]) begin
      rng_word   <= rng_tick;
      hold_level <= rng_tick[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      level <= lfo_pkg::shape_level(shape, phase_acc, hold_level);
    end
  end

  `ASSERT_CLK(a_finish_clears_phase, clk, rst, cmd.finish |=> (phase_acc == 32'd0))

endmodule

### rtl/core/lfo_waveform_generator_top.sv
// ----------------------------------------------------------------------------
// LFO waveform generator
// Low-frequency oscillator: square, triangle, saw up/down, sample and hold.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes a word with op, phase_step, seed.
//   op tick:   emits one level word (Q1.16) for the current phase, then adds
//              phase_step; a wrap steps the xorshift generator and reloads
//              the hold level. Level is valid in the cycle after acceptance.
//   op reseed: mixes seed, clears the phase, draws a new hold level.
//              Emits nothing; the next word is taken after the MUL1, MUL2
//              and FIN states (two multiply stages), in_stall high in between.
// Output channel (out_valid/out_stall) carries level from an output
//   register. While the receiver stalls, the word holds and a further tick
//   is not taken; a new tick is taken in the cycle the waiting word leaves.
// Throughput: one tick per cycle when the output is not stalled.
// Config channel (cfg_valid/cfg_ready) writes wave_shape; always ready,
//   write only while no word is in flight.
// Reset: synchronous; phase cleared, shape square, then the generator is
//   seeded with 1 in states INIT, MUL1, MUL2, FIN before the first word is taken.
// ----------------------------------------------------------------------------
module lfo_waveform_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [31:0] phase_step,
  input  logic [31:0] seed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] level,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  wave_shape
);

  lfo_pkg::lfo_cmd_t cmd;

  assign cfg_ready = 1'b1;

  lfo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lfo_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_valid  (cfg_valid),
    .wave_shape (wave_shape),
    .phase_step (phase_step),
    .seed       (seed),
    .level      (level)
  );

endmodule
